@@ rtl/hsd_pkg.sv @@
// Shared types and codes for the hex scatter string decoder.
`timescale 1ns / 1ps

package hsd_pkg;

    // Classified word handed from the front end to the back end
    typedef struct packed {
        logic       is_read;
        logic       last;
        logic       is_zero;
        logic       is_one;
        logic [3:0] digit;
    } t_cmd;

    // One result word
    typedef struct packed {
        logic       is_pair;
        logic [2:0] status;
        logic [7:0] position;
        logic [7:0] value;
        logic       final_res;
    } t_res;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_VER    = 3'd1;
    localparam logic [2:0] ST_SHORT  = 3'd2;
    localparam logic [2:0] ST_MARK   = 3'd3;
    localparam logic [2:0] ST_BEYOND = 3'd4;
    localparam logic [2:0] ST_LONG   = 3'd5;

endpackage

@@ rtl/hex_scatter_string_decoder.sv @@
// Top level of the hex scatter string decoder: front end, queue and back end.
// A load word is taken in the idle state; the word flagged last then passes through the checks
// and, when they pass, two store reads for count and offset, then staging. A read request makes
// two reads of the store's read port before staging, or goes straight to staging when it runs past the data.
// A staged result waits while the output stalls;
// a two-word queue lets input words be taken while the back end works or stalls.
// Reset (synchronous, active low) empties the queue and output and returns to loading.
`timescale 1ns / 1ps

module hex_scatter_string_decoder #(
    parameter int STORE_BYTES   = 1024,
    parameter int MIN_HEX_CHARS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_enc_char,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_pair,
    output logic [2:0] o_status,
    output logic [7:0] o_position,
    output logic [7:0] o_value,
    output logic       o_final_res
);
    import hsd_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    t_res res;

    hsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_enc_char  (i_enc_char),
        .i_last      (i_last),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    hsd_back #(
        .STORE_BYTES   (STORE_BYTES),
        .MIN_HEX_CHARS (MIN_HEX_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    assign o_is_pair   = res.is_pair;
    assign o_status    = res.status;
    assign o_position  = res.position;
    assign o_value     = res.value;
    assign o_final_res = res.final_res;

endmodule

@@ rtl/hsd_front.sv @@
// Front end: accepts input words, decodes the hex digit and queues commands.
`timescale 1ns / 1ps

module hsd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_action,
    input  logic [7:0]   i_enc_char,
    input  logic         i_last,
    output logic         o_cmd_valid,
    output hsd_pkg::t_cmd o_cmd,
    input  logic         i_cmd_pop
);
    import hsd_pkg::*;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    t_cmd       r_q [2];
    t_cmd       cmd_in;
    logic [7:0] hex_val;
    logic       push;

    // Non-hex characters count as digit 0; store the inverted digit
    always_comb begin
        hex_val = 8'd0;
        if (i_enc_char >= CHAR_ZERO && i_enc_char <= CHAR_NINE) begin
            hex_val = i_enc_char - CHAR_ZERO;
        end else if (i_enc_char >= CHAR_A && i_enc_char <= CHAR_F) begin
            hex_val = i_enc_char - CHAR_A + 8'd10;
        end
        cmd_in.is_read = i_action;
        cmd_in.last    = i_last;
        cmd_in.is_zero = (i_enc_char == CHAR_ZERO);
        cmd_in.is_one  = (i_enc_char == CHAR_ONE);
        cmd_in.digit   = ~hex_val[3:0];
    end

    assign o_ready     = (r_count != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !(i_cmd_pop && o_cmd_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop && o_cmd_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

@@ rtl/hsd_back.sv @@
// Back end: byte store, load bookkeeping, end-of-load checks and scatter reads.
`timescale 1ns / 1ps

module hsd_back #(
    parameter int STORE_BYTES   = 1024,
    parameter int MIN_HEX_CHARS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hsd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output hsd_pkg::t_res o_res
);
    import hsd_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(2 * STORE_BYTES + 5);
    localparam int NW = CW - 1;
    localparam int IW = 11;
    localparam int XW = (CW > IW) ? CW : IW;
    localparam logic [CW-1:0] CNT_CAP = CW'(2 * STORE_BYTES + 4);
    localparam logic [7:0]    MARKER_BYTE = 8'd42;

    localparam logic [1:0] PH_LOADING = 2'd0;
    localparam logic [1:0] PH_READING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_END1 = 3'd1;
    localparam logic [2:0] S_END2 = 3'd2;
    localparam logic [2:0] S_END3 = 3'd3;
    localparam logic [2:0] S_RV   = 3'd4;
    localparam logic [2:0] S_RP   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rd_data;

    logic [2:0]    r_state,    n_state;
    logic [1:0]    r_phase,    n_phase;
    logic [CW-1:0] r_cnt,      n_cnt;
    logic          r_ver,      n_ver;
    logic [3:0]    r_hi,       n_hi;
    logic [AW-1:0] r_mk_idx,   n_mk_idx;
    logic          r_mk_found, n_mk_found;
    logic [7:0]    r_total,    n_total;
    logic [8:0]    r_pair,     n_pair;
    logic          r_parity,   n_parity;
    logic [IW-1:0] r_base,     n_base;
    logic          r_o_valid,  n_o_valid;
    logic [AW-1:0] r_idx,      n_idx;
    logic [7:0]    r_v,        n_v;
    t_res          r_pend,     n_pend;
    t_res          r_res,      n_res;

    logic          take;
    logic          eff_load;
    logic [CW-1:0] eff_cnt;
    logic [CW-1:0] h;
    logic [NW-1:0] byte_idx;
    logic [7:0]    new_byte;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] hex_cnt;
    logic [NW-1:0] nbytes;
    logic [IW-1:0] rd_idx;
    logic          rd_beyond;
    logic [8:0]    pair_nx;
    logic          fin;

    assign take      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop = take;

    // A load word after a finished load starts over from a clean count
    assign eff_load = (r_phase == PH_LOADING);
    assign eff_cnt  = eff_load ? r_cnt : '0;
    assign h        = eff_cnt - CW'(2);
    assign byte_idx = h[CW-1:1];
    assign new_byte = {r_hi, i_cmd.digit};
    assign wr_addr  = byte_idx[AW-1:0];
    assign wr_en    = take && !i_cmd.is_read && (eff_cnt >= CW'(2)) && h[0]
                      && (byte_idx < NW'(STORE_BYTES));

    assign hex_cnt   = (r_cnt >= CW'(2)) ? (r_cnt - CW'(2)) : '0;
    assign nbytes    = hex_cnt[CW-1:1];
    assign rd_idx    = r_base + IW'(r_parity);
    assign rd_beyond = (XW'(rd_idx) + XW'(1)) >= XW'(nbytes);
    assign pair_nx   = r_pair + 9'd1;
    assign fin       = (pair_nx >= {1'b0, r_total});

    always_comb begin
        case (r_state)
            S_END1:  rd_addr = r_mk_idx + AW'(2);
            S_END2:  rd_addr = r_mk_idx + AW'(1);
            S_RV:    rd_addr = r_idx + AW'(1);
            default: rd_addr = rd_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= new_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_ver      = r_ver;
        n_hi       = r_hi;
        n_mk_idx   = r_mk_idx;
        n_mk_found = r_mk_found;
        n_total    = r_total;
        n_pair     = r_pair;
        n_parity   = r_parity;
        n_base     = r_base;
        n_idx      = r_idx;
        n_v        = r_v;
        n_pend     = r_pend;
        n_o_valid  = r_o_valid;
        n_res      = r_res;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (take && i_cmd.is_read) begin
                    if (r_phase == PH_READING) begin
                        if (rd_beyond) begin
                            n_pend  = '{1'b1, ST_BEYOND, 8'd0, 8'd0, 1'b1};
                            n_phase = PH_DONE;
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = rd_idx[AW-1:0];
                            n_state = S_RV;
                        end
                    end
                end else if (take) begin
                    n_phase = PH_LOADING;
                    if (!eff_load) begin
                        n_ver      = 1'b0;
                        n_mk_found = 1'b0;
                        n_mk_idx   = '0;
                        n_total    = 8'd0;
                        n_pair     = 9'd0;
                        n_parity   = 1'b0;
                        n_base     = '0;
                        n_hi       = 4'd0;
                    end
                    if (eff_cnt == CW'(0)) begin
                        n_ver = i_cmd.is_zero;
                    end else if (eff_cnt == CW'(1)) begin
                        n_ver = r_ver && i_cmd.is_one;
                    end else if (!h[0]) begin
                        n_hi = i_cmd.digit;
                    end
                    // Remember only the first marker byte
                    if (wr_en && !(eff_load && r_mk_found) && new_byte == MARKER_BYTE) begin
                        n_mk_found = 1'b1;
                        n_mk_idx   = wr_addr;
                    end
                    n_cnt = (eff_cnt < CNT_CAP) ? (eff_cnt + CW'(1)) : eff_cnt;
                    if (i_cmd.last) begin
                        n_state = S_END1;
                    end
                end
            end
            S_END1: begin
                n_state = S_EMIT;
                n_phase = PH_DONE;
                if (r_cnt < CW'(2) || !r_ver) begin
                    n_pend = '{1'b0, ST_VER, 8'd0, 8'd0, 1'b0};
                end else if (XW'(hex_cnt) < XW'(MIN_HEX_CHARS)) begin
                    n_pend = '{1'b0, ST_SHORT, 8'd0, 8'd0, 1'b0};
                end else if (nbytes > NW'(STORE_BYTES)) begin
                    n_pend = '{1'b0, ST_LONG, 8'd0, 8'd0, 1'b0};
                end else if (!r_mk_found
                             || (XW'(r_mk_idx) + XW'(2)) >= XW'(nbytes)) begin
                    n_pend = '{1'b0, ST_MARK, 8'd0, 8'd0, 1'b0};
                end else begin
                    n_state = S_END2;
                    n_phase = r_phase;
                end
            end
            S_END2: begin
                // Count byte arrives
                if (r_rd_data == 8'd0) begin
                    n_pend  = '{1'b0, ST_MARK, 8'd0, 8'd0, 1'b0};
                    n_phase = PH_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_total = r_rd_data;
                    n_state = S_END3;
                end
            end
            S_END3: begin
                // Offset byte arrives
                n_base   = IW'(r_rd_data);
                n_parity = 1'b0;
                n_pair   = 9'd0;
                n_phase  = PH_READING;
                n_pend   = '{1'b0, ST_OK, 8'd0, 8'd0, 1'b0};
                n_state  = S_EMIT;
            end
            S_RV: begin
                n_v     = r_rd_data;
                n_state = S_RP;
            end
            S_RP: begin
                n_pend   = '{1'b1, ST_OK, r_rd_data, r_v, fin};
                n_parity = r_v[0];
                n_base   = r_base + IW'(3);
                n_pair   = pair_nx;
                if (fin) begin
                    n_phase = PH_DONE;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Hold until the output register is free
                if (!r_o_valid || i_ready) begin
                    n_res     = r_pend;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_LOADING;
            r_cnt      <= '0;
            r_ver      <= 1'b0;
            r_hi       <= 4'd0;
            r_mk_idx   <= '0;
            r_mk_found <= 1'b0;
            r_total    <= 8'd0;
            r_pair     <= 9'd0;
            r_parity   <= 1'b0;
            r_base     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_ver      <= n_ver;
            r_hi       <= n_hi;
            r_mk_idx   <= n_mk_idx;
            r_mk_found <= n_mk_found;
            r_total    <= n_total;
            r_pair     <= n_pair;
            r_parity   <= n_parity;
            r_base     <= n_base;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_v    <= n_v;
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_read_phase_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READING) |-> (XW'(r_cnt) >= XW'(MIN_HEX_CHARS + 2)))
        else $error("reading phase entered with a short load");

    a_value_then_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RV) |=> (r_state == S_RP))
        else $error("position read did not follow value read");

    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_o_valid && !i_ready) |=> (r_state == S_EMIT))
        else $error("result left staging while output was busy");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_res.is_pair) |->
            (r_res.position == 8'd0 && r_res.value == 8'd0 && !r_res.final_res))
        else $error("status result carries pair data");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_pop)
        else $error("command taken while back end busy");
`endif

endmodule

@@ tb/hsd_checker.sv @@
// Scoreboard for the hex scatter string decoder: watches both channels, predicts, compares.
`timescale 1ns / 1ps

module hsd_checker #(
    parameter int STORE_BYTES   = 1024,
    parameter int MIN_HEX_CHARS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_enc_char,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_is_pair,
    input  logic [2:0] i_status,
    input  logic [7:0] i_position,
    input  logic [7:0] i_value,
    input  logic       i_final_res,
    output int         o_mismatches,
    output int         o_pending
);
    import hsd_pkg::*;

    localparam int         COUNT_CAP = 2 * STORE_BYTES + 4;
    localparam logic [7:0] MARKER    = 8'd42;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;

    typedef enum logic [1:0] {PH_LOADING, PH_READING, PH_DONE} t_phase;

    logic [7:0]  text_mem [STORE_BYTES];
    logic [3:0]  hi_nib;
    logic [11:0] n_chars;
    logic        prefix_ok;
    logic        mark_seen;
    int          mark_at;
    logic [7:0]  data_off;
    logic [7:0]  pair_total;
    logic [8:0]  pairs_done;
    logic        parity;
    t_phase      phase;
    t_res        due_q [$];

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c[3:0];
        // 'A' is 0x41, so the low nibble plus nine gives ten
        if (c >= CH_A && c <= CH_F) return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic int bytes_loaded();
        return (n_chars >= 12'd2) ? (int'(n_chars) - 2) / 2 : 0;
    endfunction

    function automatic void restart_text();
        hi_nib     = 4'd0;
        n_chars    = 12'd0;
        prefix_ok  = 1'b0;
        mark_seen  = 1'b0;
        mark_at    = 0;
        data_off   = 8'd0;
        pair_total = 8'd0;
        pairs_done = 9'd0;
        parity     = 1'b0;
        phase      = PH_LOADING;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int         h;
        logic [3:0] d;
        logic [7:0] b;
        if (n_chars == 12'd0) begin
            prefix_ok = (c == CH_ZERO);
        end else if (n_chars == 12'd1) begin
            prefix_ok = prefix_ok && (c == CH_ONE);
        end else begin
            h = int'(n_chars) - 2;
            d = 4'hF - hex_val(c);
            if (h % 2 == 0) begin
                hi_nib = d;
            end else begin
                b = {hi_nib, d};
                // drop bytes past the end of the store
                if (h / 2 < STORE_BYTES) begin
                    text_mem[h / 2] = b;
                    if (!mark_seen && b == MARKER) begin
                        mark_seen = 1'b1;
                        mark_at   = h / 2;
                    end
                end
            end
        end
        if (n_chars < COUNT_CAP) n_chars++;
    endfunction

    function automatic logic [2:0] load_status();
        int hex;
        int nb;
        hex = (n_chars >= 12'd2) ? int'(n_chars) - 2 : 0;
        nb  = hex / 2;
        if (n_chars < 12'd2 || !prefix_ok) return ST_VER;
        if (hex < MIN_HEX_CHARS) return ST_SHORT;
        if (nb > STORE_BYTES) return ST_LONG;
        if (!mark_seen || mark_at + 2 >= nb) return ST_MARK;
        if (text_mem[mark_at + 2] == 8'd0) return ST_MARK;
        data_off   = text_mem[mark_at + 1];
        pair_total = text_mem[mark_at + 2];
        return ST_OK;
    endfunction

    function automatic void decode_word(input logic is_read, input logic [7:0] c,
                                        input logic is_last);
        t_res       r;
        int         idx;
        logic [7:0] v;
        r = '0;
        if (!is_read) begin
            if (phase != PH_LOADING) restart_text();
            take_char(c);
            if (is_last) begin
                r.status   = load_status();
                phase      = (r.status == ST_OK) ? PH_READING : PH_DONE;
                pairs_done = 9'd0;
                parity     = 1'b0;
                due_q.push_back(r);
            end
        end else if (phase == PH_READING) begin
            idx       = int'(data_off) + 3 * int'(pairs_done) + int'(parity);
            r.is_pair = 1'b1;
            if (idx + 1 >= bytes_loaded()) begin
                phase       = PH_DONE;
                r.status    = ST_BEYOND;
                r.final_res = 1'b1;
            end else begin
                v          = text_mem[idx];
                r.status   = ST_OK;
                r.value    = v;
                r.position = text_mem[idx + 1];
                // low bit of this character picks the slot of the next one
                parity     = v[0];
                pairs_done++;
                r.final_res = (pairs_done >= {1'b0, pair_total});
                if (r.final_res) phase = PH_DONE;
            end
            due_q.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            restart_text();
            due_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_is_pair, i_status, i_position, i_value, i_final_res};
                if (due_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: unexpected word pair=%0d st=%0d pos=%0d val=%0d fin=%0d",
                                 $realtime, got.is_pair, got.status, got.position,
                                 got.value, got.final_res);
                end else begin
                    want = due_q.pop_front();
                    if (got.is_pair !== want.is_pair || got.status !== want.status ||
                        got.position !== want.position || got.value !== want.value ||
                        got.final_res !== want.final_res) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display({"%0t: mismatch want pair=%0d st=%0d pos=%0d val=%0d fin=%0d",
                                      " got pair=%0d st=%0d pos=%0d val=%0d fin=%0d"},
                                     $realtime, want.is_pair, want.status, want.position,
                                     want.value, want.final_res, got.is_pair, got.status,
                                     got.position, got.value, got.final_res);
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_word(i_action, i_enc_char, i_last);
        end
        o_pending = due_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the hex scatter string decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import hsd_pkg::*;

    localparam int         STORE_BYTES   = 1024;
    localparam int         MIN_HEX_CHARS = 20;
    localparam int         LIMIT         = 1000000;
    localparam int         ITEMS         = 1350;
    localparam logic       ACT_LOAD      = 1'b0;
    localparam logic       ACT_READ      = 1'b1;
    localparam logic [7:0] MARKER        = 8'd42;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_A          = 8'h41;
    localparam logic [7:0] CH_F          = 8'h46;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_action;
    logic [7:0] i_enc_char;
    logic       i_last;
    logic       o_valid;
    logic       i_ready;
    logic       o_is_pair;
    logic [2:0] o_status;
    logic [7:0] o_position;
    logic [7:0] o_value;
    logic       o_final_res;

    int         mismatches;
    int         pending;
    int         send_idle  = 0;
    int         recv_stall = 0;
    int         cycles     = 0;
    int         items      = 0;
    logic [7:0] chars_q [$];

    hex_scatter_string_decoder #(
        .STORE_BYTES  (STORE_BYTES),
        .MIN_HEX_CHARS(MIN_HEX_CHARS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_enc_char (i_enc_char),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_is_pair  (o_is_pair),
        .o_status   (o_status),
        .o_position (o_position),
        .o_value    (o_value),
        .o_final_res(o_final_res)
    );

    hsd_checker #(
        .STORE_BYTES  (STORE_BYTES),
        .MIN_HEX_CHARS(MIN_HEX_CHARS)
    ) CHK (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_action    (i_action),
        .i_enc_char  (i_enc_char),
        .i_last      (i_last),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_is_pair   (o_is_pair),
        .i_status    (o_status),
        .i_position  (o_position),
        .i_value     (o_value),
        .i_final_res (o_final_res),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Encoded character for one nibble: the digit is inverted before it is written.
    function automatic logic [7:0] nib_char(input logic [3:0] n);
        logic [3:0] d;
        logic [7:0] c;
        d = 4'hF - n;
        if (d == 4'd0 && $urandom_range(3) == 0) begin
            // any non-hex character stands for digit 0
            do c = 8'($urandom_range(255));
            while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_F));
            return c;
        end
        return (d < 4'd10) ? CH_ZERO + d : CH_A + d - 8'd10;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        chars_q.push_back(nib_char(b[7:4]));
        chars_q.push_back(nib_char(b[3:0]));
    endfunction

    // Prefix, then nb bytes: plain bytes, the marker at lead, offset, count, random data.
    function automatic void build_framed(input int lead, input logic [7:0] off,
                                         input logic [7:0] cnt, input int nb);
        logic [7:0] b;
        chars_q.delete();
        chars_q.push_back(CH_ZERO);
        chars_q.push_back(CH_ONE);
        for (int i = 0; i < nb; i++) begin
            if (i < lead) begin
                do b = 8'($urandom_range(255));
                while (b == MARKER);
                push_byte(b);
            end else if (i == lead) begin
                push_byte(MARKER);
            end else if (i == lead + 1) begin
                push_byte(off);
            end else if (i == lead + 2) begin
                push_byte(cnt);
            end else begin
                push_byte(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic send_word(input logic act, input logic [7:0] ch, input logic is_last);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_enc_char <= ch;
        i_last     <= is_last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_string();
        for (int i = 0; i < chars_q.size(); i++)
            send_word(ACT_LOAD, chars_q[i], i == chars_q.size() - 1);
        items += chars_q.size();
    endtask

    task automatic send_reads(input int n);
        repeat (n) send_word(ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        items += n;
    endtask

    // Hold the sender until every predicted word has come back.
    task automatic wait_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int lead;
        int off;
        int cnt;
        int nb;
        int nr;
        int kind;
        int str_no;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = ACT_LOAD;
        i_enc_char = 8'd0;
        i_last     = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // read while loading, with last set
        send_word(ACT_READ, 8'hFF, 1'b1);
        // one character only, then a read after the failed load
        send_word(ACT_LOAD, 8'h00, 1'b1);
        send_word(ACT_READ, 8'h00, 1'b0);
        send_word(ACT_LOAD, CH_ZERO, 1'b0);
        send_word(ACT_LOAD, 8'hFF, 1'b1);
        send_word(ACT_LOAD, CH_ONE, 1'b0);
        send_word(ACT_LOAD, CH_ZERO, 1'b1);
        // prefix alone is too short
        send_word(ACT_LOAD, CH_ZERO, 1'b0);
        send_word(ACT_LOAD, CH_ONE, 1'b1);
        send_word(ACT_READ, 8'h7F, 1'b1);
        items += 10;
        wait_results();

        str_no = 0;
        while (items < ITEMS) begin
            case (str_no % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 33; recv_stall = 33; end
            endcase
            if (str_no % 7 == 6) wait_results();
            kind = $urandom_range(99);
            if (str_no == 9) begin
                // overflow the store past the count cap
                build_framed(0, 8'd3, 8'd1, STORE_BYTES + 26);
                send_string();
                send_reads(4);
            end else if (kind < 50) begin
                lead = $urandom_range(3);
                off  = lead + 3 + $urandom_range(2);
                cnt  = $urandom_range(1, 5);
                nb   = off + 3 * cnt + $urandom_range(2);
                if (nb < MIN_HEX_CHARS / 2) nb = MIN_HEX_CHARS / 2;
                build_framed(lead, 8'(off), 8'(cnt), nb);
                // a trailing unpaired character is dropped
                if ($urandom_range(4) == 0) chars_q.push_back(8'($urandom_range(255)));
                send_string();
                // cut the read-out short now and then so a new load lands mid-read
                if ($urandom_range(5) == 0) send_reads($urandom_range(cnt - 1));
                else send_reads(cnt + $urandom_range(2));
            end else if (kind < 62) begin
                // read-out that runs past the loaded bytes
                lead = $urandom_range(3);
                off  = $urandom_range(1) ? $urandom_range(255) : lead + 3;
                cnt  = $urandom_range(1) ? 255 : $urandom_range(1, 255);
                build_framed(lead, 8'(off), 8'(cnt), $urandom_range(10, 24));
                send_string();
                send_reads($urandom_range(1, 8));
            end else if (kind < 70) begin
                build_framed(0, 8'd3, 8'd1, 10);
                chars_q[$urandom_range(1)] = 8'($urandom_range(255));
                send_string();
                send_reads(2);
            end else if (kind < 78) begin
                chars_q.delete();
                chars_q.push_back(CH_ZERO);
                chars_q.push_back(CH_ONE);
                repeat ($urandom_range(MIN_HEX_CHARS - 1))
                    chars_q.push_back(nib_char(4'($urandom_range(15))));
                send_string();
                send_reads(1);
            end else if (kind < 88) begin
                // marker missing, in the last two bytes, or followed by a zero count
                nb = $urandom_range(10, 16);
                case ($urandom_range(2))
                    0: build_framed(nb, 8'd0, 8'd0, nb);
                    1: build_framed(nb - 1 - $urandom_range(1), 8'($urandom_range(255)),
                                    8'd1, nb);
                    default: build_framed($urandom_range(3), 8'd6, 8'd0, nb);
                endcase
                send_string();
                send_reads(1);
            end else begin
                // loose words, closed by a last character so the next string starts clean
                nr = $urandom_range(1, 12);
                repeat (nr)
                    send_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                              $urandom_range(9) == 0);
                send_word(ACT_LOAD, 8'($urandom_range(255)), 1'b1);
                items += nr + 1;
            end
            str_no++;
        end

        wait_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hsd_pkg.sv
rtl/hsd_front.sv
rtl/hsd_back.sv
rtl/hex_scatter_string_decoder.sv
tb/hsd_checker.sv
tb/tb_top.sv
